### hdl/cfa_pkg.sv
package cfa_pkg;

   localparam int WORD_BITS_DEF = 32;
   localparam int FRAC_BITS_DEF = 16;

   typedef enum logic [2:0] {
      ACT_ADD = 3'd0,
      ACT_SUB = 3'd1,
      ACT_MUL = 3'd2,
      ACT_DIV = 3'd3,
      ACT_INC = 3'd4,
      ACT_DEC = 3'd5,
      ACT_CMP = 3'd6
   } action_type;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_SAT  = 2'd1;
   localparam logic [1:0] ST_DIV0 = 2'd2;

   localparam logic [1:0] ORD_LESS    = 2'd0;
   localparam logic [1:0] ORD_EQUAL   = 2'd1;
   localparam logic [1:0] ORD_GREATER = 2'd2;

   // per-item control that rides along the divider stages
   typedef struct packed {
      logic       is_div;
      logic       dz;
      logic [1:0] order;
      logic [1:0] status;
   } tag_type;

endpackage

### hdl/cfa_front.sv
module cfa_front
   import cfa_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [2:0]                    req_action,
   input  logic signed [WORD_BITS-1:0]   req_a_re,
   input  logic signed [WORD_BITS-1:0]   req_a_im,
   input  logic signed [WORD_BITS-1:0]   req_b_re,
   input  logic signed [WORD_BITS-1:0]   req_b_im,
   output logic                          c_valid,
   input  logic                          c_ready,
   output logic [2*WORD_BITS-1:0]        c_rem [2],
   output logic [WORD_BITS:0]            c_x [2],
   output logic [1:0]                    c_neg,
   output logic [1:0]                    c_ovf,
   output logic [2*WORD_BITS-1:0]        c_den,
   output tag_type                       c_tag,
   output logic [WORD_BITS-1:0]          c_res_re,
   output logic [WORD_BITS-1:0]          c_res_im
);

   localparam int W  = WORD_BITS;
   localparam int F  = FRAC_BITS;
   localparam int PW = 2 * W;
   localparam int SW = 2 * W + 1;
   localparam int AW = ((F > W) ? F : W) + 2;
   localparam int XW = PW + F;
   localparam int CW = PW + W + 1 + F;

   localparam logic signed [AW-1:0] MAXV = (AW'(1) << (W - 1)) - AW'(1);
   localparam logic signed [AW-1:0] MINV = ~MAXV;
   localparam logic signed [AW-1:0] ONE  = AW'(1) << F;
   localparam logic [SW-1:0] RND  = SW'(1) << (F - 1);
   localparam logic [SW-1:0] HALF = SW'(1) << (W - 1);

   // handshake
   logic va_ff, vb_ff, vc_ff;
   logic rdy_a, rdy_b, rdy_c;

   assign rdy_c     = !vc_ff || c_ready;
   assign rdy_b     = !vb_ff || rdy_c;
   assign rdy_a     = !va_ff || rdy_b;
   assign req_stall = !rdy_a;
   assign c_valid   = vc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         if (rdy_a) va_ff <= req_valid;
         if (rdy_b) vb_ff <= va_ff;
         if (rdy_c) vc_ff <= vb_ff;
      end
   end

   // stage A: products and the plain add paths
   logic signed [PW-1:0] p_rr_in, p_ii_in, p_ri_in, p_ir_in;
   logic signed [PW-1:0] sq_ar_in, sq_ai_in, sq_br_in, sq_bi_in;
   logic signed [AW-1:0] add_re, add_im, sum_re, sum_im;
   logic [W-1:0]         s_re_in, s_im_in;
   logic                 s_sat_in;

   assign p_rr_in  = PW'(req_a_re) * PW'(req_b_re);
   assign p_ii_in  = PW'(req_a_im) * PW'(req_b_im);
   assign p_ri_in  = PW'(req_a_re) * PW'(req_b_im);
   assign p_ir_in  = PW'(req_a_im) * PW'(req_b_re);
   assign sq_ar_in = PW'(req_a_re) * PW'(req_a_re);
   assign sq_ai_in = PW'(req_a_im) * PW'(req_a_im);
   assign sq_br_in = PW'(req_b_re) * PW'(req_b_re);
   assign sq_bi_in = PW'(req_b_im) * PW'(req_b_im);

   always_comb begin
      add_re = '0;
      add_im = '0;
      unique case (req_action)
         ACT_ADD: begin
            add_re = AW'(req_b_re);
            add_im = AW'(req_b_im);
         end
         ACT_SUB: begin
            add_re = -AW'(req_b_re);
            add_im = -AW'(req_b_im);
         end
         ACT_INC: begin
            add_re = ONE;
            add_im = ONE;
         end
         ACT_DEC: begin
            add_re = -ONE;
            add_im = -ONE;
         end
         default: begin
            add_re = '0;
            add_im = '0;
         end
      endcase
   end

   assign sum_re = AW'(req_a_re) + add_re;
   assign sum_im = AW'(req_a_im) + add_im;

   always_comb begin
      s_sat_in = 1'b0;
      if (sum_re > MAXV) begin
         s_re_in  = MAXV[W-1:0];
         s_sat_in = 1'b1;
      end else if (sum_re < MINV) begin
         s_re_in  = MINV[W-1:0];
         s_sat_in = 1'b1;
      end else begin
         s_re_in = sum_re[W-1:0];
      end
      if (sum_im > MAXV) begin
         s_im_in  = MAXV[W-1:0];
         s_sat_in = 1'b1;
      end else if (sum_im < MINV) begin
         s_im_in  = MINV[W-1:0];
         s_sat_in = 1'b1;
      end else begin
         s_im_in = sum_im[W-1:0];
      end
   end

   logic [2:0]           act_a_ff, act_b_ff;
   logic signed [PW-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic signed [PW-1:0] sq_ar_ff, sq_ai_ff, sq_br_ff, sq_bi_ff;
   logic [W-1:0]         s_re_a_ff, s_im_a_ff, s_re_b_ff, s_im_b_ff;
   logic                 s_sat_a_ff, s_sat_b_ff;

   // stage B: sums of products
   logic signed [SW-1:0] mul_in [2];
   logic signed [SW-1:0] dnum_in [2];
   logic [PW-1:0]        den_in, ma_in;
   logic signed [SW-1:0] mul_ff [2];
   logic signed [SW-1:0] dnum_ff [2];
   logic [PW-1:0]        den_ff, ma_ff;

   assign mul_in[0]  = SW'(p_rr_ff) - SW'(p_ii_ff);
   assign mul_in[1]  = SW'(p_ri_ff) + SW'(p_ir_ff);
   assign dnum_in[0] = SW'(p_rr_ff) + SW'(p_ii_ff);
   assign dnum_in[1] = SW'(p_ir_ff) - SW'(p_ri_ff);
   assign den_in     = PW'($unsigned(sq_br_ff)) + PW'($unsigned(sq_bi_ff));
   assign ma_in      = PW'($unsigned(sq_ar_ff)) + PW'($unsigned(sq_ai_ff));

   // stage C: multiply rounding, divider setup, compare
   logic [W-1:0]  mres [2];
   logic [1:0]    msat;
   logic [PW-1:0] rem_in [2];
   logic [W:0]    x_in [2];
   logic [1:0]    neg_in, ovf_in;

   for (genvar l = 0; l < 2; l++) begin : g_lane
      logic          m_neg, m_sat, d_neg;
      logic [SW-1:0] m_mag, m_rnd, m_lim, d_mag;
      logic [W-1:0]  m_val;
      logic [XW-1:0] d_x, d_xs;

      assign m_neg   = mul_ff[l][SW-1];
      assign m_mag   = m_neg ? $unsigned(-mul_ff[l]) : $unsigned(mul_ff[l]);
      assign m_rnd   = (m_mag + RND) >> F;
      assign m_lim   = m_neg ? HALF : HALF - SW'(1);
      assign m_sat   = m_rnd > m_lim;
      assign m_val   = m_sat ? m_lim[W-1:0] : m_rnd[W-1:0];
      assign mres[l] = m_neg ? -m_val : m_val;
      assign msat[l] = m_sat;

      assign d_neg     = dnum_ff[l][SW-1];
      assign d_mag     = d_neg ? $unsigned(-dnum_ff[l]) : $unsigned(dnum_ff[l]);
      assign d_x       = {d_mag[PW-1:0], {F{1'b0}}};
      // quotient beyond W+1 bits saturates anyway
      assign ovf_in[l] = CW'(d_x) >= (CW'(den_ff) << (W + 1));
      assign d_xs      = d_x >> (W + 1);
      assign rem_in[l] = d_xs[PW-1:0];
      assign x_in[l]   = d_x[W:0];
      assign neg_in[l] = d_neg;
   end

   tag_type      tag_in;
   logic [W-1:0] res_re_in, res_im_in;

   always_comb begin
      tag_in.is_div = 1'b0;
      tag_in.dz     = (den_ff == '0);
      tag_in.order  = ORD_LESS;
      tag_in.status = ST_OK;
      res_re_in     = '0;
      res_im_in     = '0;
      unique case (act_b_ff)
         ACT_ADD, ACT_SUB, ACT_INC, ACT_DEC: begin
            res_re_in = s_re_b_ff;
            res_im_in = s_im_b_ff;
            if (s_sat_b_ff) tag_in.status = ST_SAT;
         end
         ACT_MUL: begin
            res_re_in = mres[0];
            res_im_in = mres[1];
            if (|msat) tag_in.status = ST_SAT;
         end
         ACT_DIV: tag_in.is_div = 1'b1;
         ACT_CMP: begin
            if (ma_ff > den_ff) tag_in.order = ORD_GREATER;
            else if (ma_ff == den_ff) tag_in.order = ORD_EQUAL;
            else tag_in.order = ORD_LESS;
         end
         default: tag_in.status = ST_OK;
      endcase
   end

   logic [PW-1:0] rem_ff [2];
   logic [W:0]    x_ff [2];
   logic [1:0]    neg_ff, ovf_ff;
   logic [PW-1:0] den_c_ff;
   tag_type       tag_ff;
   logic [W-1:0]  res_re_ff, res_im_ff;

   always_ff @(posedge clock) begin
      if (rdy_a) begin
         act_a_ff   <= req_action;
         p_rr_ff    <= p_rr_in;
         p_ii_ff    <= p_ii_in;
         p_ri_ff    <= p_ri_in;
         p_ir_ff    <= p_ir_in;
         sq_ar_ff   <= sq_ar_in;
         sq_ai_ff   <= sq_ai_in;
         sq_br_ff   <= sq_br_in;
         sq_bi_ff   <= sq_bi_in;
         s_re_a_ff  <= s_re_in;
         s_im_a_ff  <= s_im_in;
         s_sat_a_ff <= s_sat_in;
      end
      if (rdy_b) begin
         act_b_ff   <= act_a_ff;
         mul_ff     <= mul_in;
         dnum_ff    <= dnum_in;
         den_ff     <= den_in;
         ma_ff      <= ma_in;
         s_re_b_ff  <= s_re_a_ff;
         s_im_b_ff  <= s_im_a_ff;
         s_sat_b_ff <= s_sat_a_ff;
      end
      if (rdy_c) begin
         rem_ff    <= rem_in;
         x_ff      <= x_in;
         neg_ff    <= neg_in;
         ovf_ff    <= ovf_in;
         den_c_ff  <= den_ff;
         tag_ff    <= tag_in;
         res_re_ff <= res_re_in;
         res_im_ff <= res_im_in;
      end
   end

   assign c_rem    = rem_ff;
   assign c_x      = x_ff;
   assign c_neg    = neg_ff;
   assign c_ovf    = ovf_ff;
   assign c_den    = den_c_ff;
   assign c_tag    = tag_ff;
   assign c_res_re = res_re_ff;
   assign c_res_im = res_im_ff;

endmodule

### hdl/cfa_div.sv
module cfa_div
   import cfa_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [2*WORD_BITS-1:0] in_rem [2],
   input  logic [WORD_BITS:0]     in_x [2],
   input  logic [1:0]             in_neg,
   input  logic [1:0]             in_ovf,
   input  logic [2*WORD_BITS-1:0] in_den,
   input  tag_type                in_tag,
   input  logic [WORD_BITS-1:0]   in_res_re,
   input  logic [WORD_BITS-1:0]   in_res_im,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [2*WORD_BITS-1:0] out_rem [2],
   output logic [WORD_BITS:0]     out_q [2],
   output logic [1:0]             out_neg,
   output logic [1:0]             out_ovf,
   output logic [2*WORD_BITS-1:0] out_den,
   output tag_type                out_tag,
   output logic [WORD_BITS-1:0]   out_res_re,
   output logic [WORD_BITS-1:0]   out_res_im
);

   localparam int W  = WORD_BITS;
   localparam int PW = 2 * W;
   localparam int SW = 2 * W + 1;
   localparam int N  = W + 1;

   logic [N-1:0]  v_ff, v_up, rdy;
   logic [PW-1:0] rem_ff [N][2];
   logic [PW-1:0] rem_up [N][2];
   logic [PW-1:0] rem_in [N][2];
   logic [W:0]    q_ff [N][2];
   logic [W:0]    q_up [N][2];
   logic [W:0]    q_in [N][2];
   logic [W:0]    x_ff [N][2];
   logic [W:0]    x_up [N][2];
   logic [W:0]    x_in [N][2];
   logic [1:0]    neg_ff [N];
   logic [1:0]    neg_up [N];
   logic [1:0]    ovf_ff [N];
   logic [1:0]    ovf_up [N];
   logic [PW-1:0] den_ff [N];
   logic [PW-1:0] den_up [N];
   tag_type       tag_ff [N];
   tag_type       tag_up [N];
   logic [W-1:0]  rre_ff [N];
   logic [W-1:0]  rre_up [N];
   logic [W-1:0]  rim_ff [N];
   logic [W-1:0]  rim_up [N];

   for (genvar s = 0; s < N; s++) begin : g_step
      if (s == 0) begin : g_first
         assign v_up[s]   = in_valid;
         assign rem_up[s] = in_rem;
         assign q_up[s]   = '{'0, '0};
         assign x_up[s]   = in_x;
         assign neg_up[s] = in_neg;
         assign ovf_up[s] = in_ovf;
         assign den_up[s] = in_den;
         assign tag_up[s] = in_tag;
         assign rre_up[s] = in_res_re;
         assign rim_up[s] = in_res_im;
      end else begin : g_next
         assign v_up[s]   = v_ff[s-1];
         assign rem_up[s] = rem_ff[s-1];
         assign q_up[s]   = q_ff[s-1];
         assign x_up[s]   = x_ff[s-1];
         assign neg_up[s] = neg_ff[s-1];
         assign ovf_up[s] = ovf_ff[s-1];
         assign den_up[s] = den_ff[s-1];
         assign tag_up[s] = tag_ff[s-1];
         assign rre_up[s] = rre_ff[s-1];
         assign rim_up[s] = rim_ff[s-1];
      end

      if (s == N - 1) begin : g_last
         assign rdy[s] = !v_ff[s] || out_ready;
      end else begin : g_mid
         assign rdy[s] = !v_ff[s] || rdy[s+1];
      end

      // one restoring quotient bit per stage
      for (genvar l = 0; l < 2; l++) begin : g_lane
         logic [SW-1:0] sh, diff;
         logic          ge;

         assign sh          = {rem_up[s][l], x_up[s][l][W]};
         assign ge          = sh >= {1'b0, den_up[s]};
         assign diff        = sh - {1'b0, den_up[s]};
         assign rem_in[s][l] = ge ? diff[PW-1:0] : sh[PW-1:0];
         assign q_in[s][l]   = {q_up[s][l][W-1:0], ge};
         assign x_in[s][l]   = {x_up[s][l][W-1:0], 1'b0};
      end
   end

   assign in_ready = rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int s = 0; s < N; s++) begin
            if (rdy[s]) v_ff[s] <= v_up[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < N; s++) begin
         if (rdy[s]) begin
            rem_ff[s] <= rem_in[s];
            q_ff[s]   <= q_in[s];
            x_ff[s]   <= x_in[s];
            neg_ff[s] <= neg_up[s];
            ovf_ff[s] <= ovf_up[s];
            den_ff[s] <= den_up[s];
            tag_ff[s] <= tag_up[s];
            rre_ff[s] <= rre_up[s];
            rim_ff[s] <= rim_up[s];
         end
      end
   end

   assign out_valid  = v_ff[N-1];
   assign out_rem    = rem_ff[N-1];
   assign out_q      = q_ff[N-1];
   assign out_neg    = neg_ff[N-1];
   assign out_ovf    = ovf_ff[N-1];
   assign out_den    = den_ff[N-1];
   assign out_tag    = tag_ff[N-1];
   assign out_res_re = rre_ff[N-1];
   assign out_res_im = rim_ff[N-1];

endmodule

### hdl/cfa_back.sv
module cfa_back
   import cfa_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [2*WORD_BITS-1:0] in_rem [2],
   input  logic [WORD_BITS:0]     in_q [2],
   input  logic [1:0]             in_neg,
   input  logic [1:0]             in_ovf,
   input  logic [2*WORD_BITS-1:0] in_den,
   input  tag_type                in_tag,
   input  logic [WORD_BITS-1:0]   in_res_re,
   input  logic [WORD_BITS-1:0]   in_res_im,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [WORD_BITS-1:0]   rsp_res_re,
   output logic [WORD_BITS-1:0]   rsp_res_im,
   output logic [1:0]             rsp_order,
   output logic [1:0]             rsp_status
);

   localparam int W  = WORD_BITS;
   localparam int SW = 2 * W + 1;
   localparam logic [W+1:0] HALF = (W + 2)'(1) << (W - 1);

   logic [W-1:0] dres [2];
   logic [1:0]   dsat;

   for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [SW-1:0] twice;
      logic          up, sat;
      logic [W+1:0]  qr, lim;
      logic [W-1:0]  val;

      // round half away from zero on the remainder
      assign twice   = {in_rem[l], 1'b0};
      assign up      = twice >= SW'(in_den);
      assign qr      = (W + 2)'(in_q[l]) + (W + 2)'(up);
      assign lim     = in_neg[l] ? HALF : HALF - (W + 2)'(1);
      assign sat     = in_ovf[l] || (qr > lim);
      assign val     = sat ? lim[W-1:0] : qr[W-1:0];
      assign dres[l] = in_neg[l] ? -val : val;
      assign dsat[l] = sat;
   end

   logic [W-1:0] res_re_in, res_im_in;
   logic [1:0]   order_in, status_in;

   always_comb begin
      res_re_in = in_res_re;
      res_im_in = in_res_im;
      order_in  = in_tag.order;
      status_in = in_tag.status;
      priority if (in_tag.is_div && in_tag.dz) begin
         res_re_in = '0;
         res_im_in = '0;
         order_in  = ORD_LESS;
         status_in = ST_DIV0;
      end else if (in_tag.is_div) begin
         res_re_in = dres[0];
         res_im_in = dres[1];
         order_in  = ORD_LESS;
         status_in = (|dsat) ? ST_SAT : ST_OK;
      end else begin
         res_re_in = in_res_re;
         res_im_in = in_res_im;
         order_in  = in_tag.order;
         status_in = in_tag.status;
      end
   end

   logic         rsp_valid_ff;
   logic [W-1:0] res_re_ff, res_im_ff;
   logic [1:0]   order_ff, status_ff;

   assign in_ready = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (in_ready) rsp_valid_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         res_re_ff <= res_re_in;
         res_im_ff <= res_im_in;
         order_ff  <= order_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_res_re = res_re_ff;
   assign rsp_res_im = res_im_ff;
   assign rsp_order  = order_ff;
   assign rsp_status = status_ff;

endmodule

### hdl/complex_fixed_point_alu_top.sv
// Complex fixed-point ALU: add, subtract, multiply, divide, increment,
// decrement and magnitude compare on signed Q(WORD_BITS-FRAC_BITS).FRAC_BITS
// operands. One beat is taken per cycle unless req_stall is high, and one
// result beat comes out per input beat, in order. The path runs through
// three front stages (products, sums, rounding and divider setup),
// a restoring divider of WORD_BITS + 1 stages that settles one quotient bit
// per stage, and the output register. Multiply and divide round to nearest
// with ties away from zero; overflow saturates with status 1, a zero divisor
// gives a zero result with status 2. Stalls collapse bubbles stage by stage.
module complex_fixed_point_alu_top
   import cfa_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [2:0]                  req_action,
   input  logic signed [WORD_BITS-1:0] req_a_re,
   input  logic signed [WORD_BITS-1:0] req_a_im,
   input  logic signed [WORD_BITS-1:0] req_b_re,
   input  logic signed [WORD_BITS-1:0] req_b_im,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [WORD_BITS-1:0] rsp_res_re,
   output logic signed [WORD_BITS-1:0] rsp_res_im,
   output logic [1:0]                  rsp_order,
   output logic [1:0]                  rsp_status
);

   localparam int W  = WORD_BITS;
   localparam int PW = 2 * W;

   logic          c_valid, c_ready;
   logic [PW-1:0] c_rem [2];
   logic [W:0]    c_x [2];
   logic [1:0]    c_neg, c_ovf;
   logic [PW-1:0] c_den;
   tag_type       c_tag;
   logic [W-1:0]  c_res_re, c_res_im;

   logic          d_valid, d_ready;
   logic [PW-1:0] d_rem [2];
   logic [W:0]    d_q [2];
   logic [1:0]    d_neg, d_ovf;
   logic [PW-1:0] d_den;
   tag_type       d_tag;
   logic [W-1:0]  d_res_re, d_res_im;

   cfa_front #(
      .WORD_BITS (WORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_action (req_action),
      .req_a_re   (req_a_re),
      .req_a_im   (req_a_im),
      .req_b_re   (req_b_re),
      .req_b_im   (req_b_im),
      .c_valid    (c_valid),
      .c_ready    (c_ready),
      .c_rem      (c_rem),
      .c_x        (c_x),
      .c_neg      (c_neg),
      .c_ovf      (c_ovf),
      .c_den      (c_den),
      .c_tag      (c_tag),
      .c_res_re   (c_res_re),
      .c_res_im   (c_res_im)
   );

   cfa_div #(
      .WORD_BITS (WORD_BITS)
   ) u_div (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (c_valid),
      .in_ready   (c_ready),
      .in_rem     (c_rem),
      .in_x       (c_x),
      .in_neg     (c_neg),
      .in_ovf     (c_ovf),
      .in_den     (c_den),
      .in_tag     (c_tag),
      .in_res_re  (c_res_re),
      .in_res_im  (c_res_im),
      .out_valid  (d_valid),
      .out_ready  (d_ready),
      .out_rem    (d_rem),
      .out_q      (d_q),
      .out_neg    (d_neg),
      .out_ovf    (d_ovf),
      .out_den    (d_den),
      .out_tag    (d_tag),
      .out_res_re (d_res_re),
      .out_res_im (d_res_im)
   );

   cfa_back #(
      .WORD_BITS (WORD_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (d_valid),
      .in_ready   (d_ready),
      .in_rem     (d_rem),
      .in_q       (d_q),
      .in_neg     (d_neg),
      .in_ovf     (d_ovf),
      .in_den     (d_den),
      .in_tag     (d_tag),
      .in_res_re  (d_res_re),
      .in_res_im  (d_res_im),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_res_re (rsp_res_re),
      .rsp_res_im (rsp_res_im),
      .rsp_order  (rsp_order),
      .rsp_status (rsp_status)
   );

   a_div0_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_DIV0 |-> rsp_res_re == '0 && rsp_res_im == '0)
      else $error("divide by zero result not cleared");

   a_order_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_order != ORD_LESS |-> rsp_status == ST_OK)
      else $error("nonzero order with error status");

   a_order_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_order == ORD_LESS || rsp_order == ORD_EQUAL
                    || rsp_order == ORD_GREATER)
      else $error("bad order code");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result beat right after reset");

endmodule
